[design/stack_accumulator_machine_macros.svh]
// ----------------------------------------------------------------------------
// stack_accumulator_machine_macros
// assertion macros for the stack accumulator machine rtl
// ----------------------------------------------------------------------------
`ifndef STACK_ACCUMULATOR_MACHINE_MACROS_SVH
`define STACK_ACCUMULATOR_MACHINE_MACROS_SVH

`ifndef SYNTHESIS
// property checked only while out of reset
`define SAM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// property checked at every edge, reset included
`define SAM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SAM_ASSERT(lbl, clk, rstn, prop, msg)
`define SAM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[design/sam_pkg.sv]
// ----------------------------------------------------------------------------
// sam_pkg
// shared widths, operation and status codes for the stack accumulator machine
// ----------------------------------------------------------------------------
package sam_pkg;

    localparam int DATA_W          = 32;
    localparam int FUNC_W          = 3;
    localparam int DEPTH_W         = 5;
    localparam int STATUS_W        = 2;
    localparam int STACK_DEPTH_DEF = 16;

    localparam logic [FUNC_W-1:0] FUNC_PUSH = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_ADD  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SUB  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CMP  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;

    // control decisions of one executed item
    typedef struct packed {
        logic                inc;       // count goes up by one
        logic                dec;       // count goes down by one
        logic                wr_below;  // old top moves into the ram
        logic [STATUS_W-1:0] status;
    } t_exec_ctl;

endpackage

[design/sam_ram.sv]
// ----------------------------------------------------------------------------
// sam_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module sam_ram #(
    parameter int  WIDTH  = 32,
    parameter int  DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/sam_exec.sv]
// ----------------------------------------------------------------------------
// sam_exec
// decodes one instruction and computes new top, accumulator and count moves
// ----------------------------------------------------------------------------
module sam_exec #(
    parameter int  STACK_DEPTH = sam_pkg::STACK_DEPTH_DEF,
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1)
) (
    input  logic [sam_pkg::FUNC_W-1:0] i_func,
    input  logic [sam_pkg::DATA_W-1:0] i_imm,
    input  logic [sam_pkg::DATA_W-1:0] i_top,
    input  logic [sam_pkg::DATA_W-1:0] i_below,
    input  logic [sam_pkg::DATA_W-1:0] i_acc,
    input  logic [CNT_W-1:0]           i_count,
    output logic [sam_pkg::DATA_W-1:0] o_top,
    output logic [sam_pkg::DATA_W-1:0] o_acc,
    output sam_pkg::t_exec_ctl         o_ctl
);

    import sam_pkg::*;

    logic empty;
    logic full;
    logic [DATA_W-1:0] cmp_val;

    assign empty = (i_count == '0);
    assign full  = (i_count == CNT_W'(STACK_DEPTH));

    always_comb begin
        if ($signed(i_top) > $signed(i_acc)) begin
            cmp_val = DATA_W'(1);
        end else if ($signed(i_top) < $signed(i_acc)) begin
            cmp_val = '1;
        end else begin
            cmp_val = '0;
        end
    end

    always_comb begin
        o_top            = i_top;
        o_acc            = i_acc;
        o_ctl.inc        = 1'b0;
        o_ctl.dec        = 1'b0;
        o_ctl.wr_below   = 1'b0;
        o_ctl.status     = ST_OK;
        case (i_func)
            FUNC_PUSH: begin
                if (full) begin
                    o_ctl.status = ST_OVER;
                end else begin
                    o_top          = i_imm;
                    o_ctl.inc      = 1'b1;
                    o_ctl.wr_below = !empty;
                end
            end
            FUNC_POP, FUNC_ADD, FUNC_SUB, FUNC_CMP: begin
                if (empty) begin
                    o_ctl.status = ST_UNDER;
                end else if (i_func == FUNC_CMP) begin
                    o_top = cmp_val;
                end else begin
                    o_top     = i_below;
                    o_ctl.dec = 1'b1;
                    if (i_func == FUNC_POP) begin
                        o_acc = i_top;
                    end else if (i_func == FUNC_ADD) begin
                        o_acc = i_acc + i_top;
                    end else begin
                        o_acc = i_acc - i_top;
                    end
                end
            end
            default: begin
                // unused codes leave everything as it is
                o_top = i_top;
            end
        endcase
    end

endmodule

[design/stack_accumulator_machine.sv]
// ----------------------------------------------------------------------------
// stack_accumulator_machine
// pipeline: input reg, then result reg; an output stall holds the item in the input reg
// throughput: one item per cycle while the output is not stalled; top of stack and
// the entry below it are held so the ram's registered read never stalls the execute stage
// reset: synchronous active low, clears count, accumulator and valids
// ----------------------------------------------------------------------------
`include "stack_accumulator_machine_macros.svh"

module stack_accumulator_machine #(
    parameter int STACK_DEPTH = sam_pkg::STACK_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic        [sam_pkg::FUNC_W-1:0]   i_func,
    input  logic signed [sam_pkg::DATA_W-1:0]   i_immediate,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [sam_pkg::DATA_W-1:0]   o_accumulator,
    output logic signed [sam_pkg::DATA_W-1:0]   o_top_value,
    output logic        [sam_pkg::DEPTH_W-1:0]  o_depth,
    output logic        [sam_pkg::STATUS_W-1:0] o_status
);

    import sam_pkg::*;

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // input register
    logic              r_in_valid;
    logic [FUNC_W-1:0] r_func;
    logic [DATA_W-1:0] r_imm;

    // architectural state
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [DATA_W-1:0] r_top;
    logic [DATA_W-1:0] r_acc;

    // ram forwarding
    logic              r_fwd_vld;
    logic [DATA_W-1:0] r_fwd_data;
    logic [DATA_W-1:0] ram_rdata;
    logic [DATA_W-1:0] below;
    logic [CNT_W-1:0]  wr_idx;
    logic [CNT_W-1:0]  rd_idx;
    logic              ram_wr;

    // result register
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_out_acc;
    logic [DATA_W-1:0]   r_out_top;
    logic [DEPTH_W-1:0]  r_out_depth;
    logic [STATUS_W-1:0] r_out_status;

    logic               exec_fire;
    logic               in_fire;
    logic [DATA_W-1:0]  exe_top;
    logic [DATA_W-1:0]  exe_acc;
    t_exec_ctl          exe_ctl;
    logic [DEPTH_W+CNT_W-1:0] depth_ext;

    assign exec_fire  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !exec_fire;
    assign in_fire    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (exec_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_func <= i_func;
            r_imm  <= i_immediate;
        end
    end

    assign below = r_fwd_vld ? r_fwd_data : ram_rdata;

    sam_exec #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_exec (
        .i_func  (r_func),
        .i_imm   (r_imm),
        .i_top   (r_top),
        .i_below (below),
        .i_acc   (r_acc),
        .i_count (r_count),
        .o_top   (exe_top),
        .o_acc   (exe_acc),
        .o_ctl   (exe_ctl)
    );

    always_comb begin
        n_count = r_count;
        if (exec_fire && exe_ctl.inc) begin
            n_count = r_count + CNT_W'(1);
        end else if (exec_fire && exe_ctl.dec) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // ram holds every entry below the top; read the one under the next top
    assign ram_wr = exec_fire && exe_ctl.wr_below;
    assign wr_idx = r_count - CNT_W'(1);
    assign rd_idx = n_count - CNT_W'(2);

    sam_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr),
        .i_wr_addr (wr_idx[ADDR_W-1:0]),
        .i_wr_data (r_top),
        .i_rd_addr (rd_idx[ADDR_W-1:0]),
        .o_rd_data (ram_rdata)
    );

    // read and write of the same entry in one cycle: ram returns old data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld <= 1'b0;
        end else begin
            r_fwd_vld <= ram_wr && (wr_idx[ADDR_W-1:0] == rd_idx[ADDR_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= r_top;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_acc   <= '0;
        end else begin
            r_count <= n_count;
            if (exec_fire) begin
                r_acc <= exe_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_top <= exe_top;
        end
    end

    assign depth_ext = {{DEPTH_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_out_acc    <= exe_acc;
            r_out_top    <= (n_count == '0) ? '0 : exe_top;
            r_out_depth  <= depth_ext[DEPTH_W-1:0];
            r_out_status <= exe_ctl.status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_accumulator = r_out_acc;
    assign o_top_value   = r_out_top;
    assign o_depth       = r_out_depth;
    assign o_status      = r_out_status;

    `SAM_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
    `SAM_ASSERT(a_err_holds, i_clk, i_rst_n, (exec_fire && exe_ctl.status != ST_OK) |=> (r_count == $past(r_count)), "error item changed the count")
    `SAM_ASSERT(a_push_inc, i_clk, i_rst_n, (exec_fire && exe_ctl.inc) |=> (r_count == $past(r_count) + CNT_W'(1)), "push did not grow the stack")
    `SAM_ASSERT(a_exec_result, i_clk, i_rst_n, exec_fire |=> r_out_valid, "executed item has no result")
    `SAM_ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> (!r_out_valid && !r_in_valid && r_count == '0), "reset left state behind")

endmodule

[dv/stack_accumulator_machine_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stack_accumulator_machine_tb
// drives instructions through the stack accumulator machine with random gaps
// and output stalls, tracks stack and accumulator in a scoreboard and checks
// every result field against the tracked state
// ----------------------------------------------------------------------------
module stack_accumulator_machine_tb;
    import sam_pkg::*;

    localparam int STACK_DEPTH = STACK_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 900;

    // operations the block treats as no-ops
    localparam logic [FUNC_W-1:0] FUNC_RSVD5 = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_RSVD6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_RSVD7 = 3'd7;

    localparam logic [DATA_W-1:0] VAL_MAX = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [DATA_W-1:0]   acc;
        logic [DATA_W-1:0]   top;
        logic [DEPTH_W-1:0]  depth;
        logic [STATUS_W-1:0] status;
    } t_sam_state;

    class stack_machine_tracker;
        logic [DATA_W-1:0] entries [STACK_DEPTH];
        int unsigned       count;
        logic [DATA_W-1:0] acc;
        t_sam_state        pending [$];
        int                errors;

        function new();
            count = 0;
            acc = '0;
            errors = 0;
        endfunction

        // note an accepted instruction and queue the state it should leave
        function void execute_instr(logic [FUNC_W-1:0] op, logic [DATA_W-1:0] imm);
            logic [STATUS_W-1:0] st;
            logic [DATA_W-1:0]   t;
            t_sam_state          s;
            st = ST_OK;
            if (op == FUNC_PUSH) begin
                if (count >= STACK_DEPTH) begin
                    st = ST_OVER;
                end else begin
                    entries[count] = imm;
                    count++;
                end
            end else if (op == FUNC_POP || op == FUNC_ADD || op == FUNC_SUB ||
                         op == FUNC_CMP) begin
                if (count == 0) begin
                    st = ST_UNDER;
                end else begin
                    t = entries[count-1];
                    case (op)
                        FUNC_POP: begin
                            acc = t;
                            count--;
                        end
                        FUNC_ADD: begin
                            acc = acc + t;
                            count--;
                        end
                        FUNC_SUB: begin
                            acc = acc - t;
                            count--;
                        end
                        default: begin
                            if ($signed(t) > $signed(acc))
                                entries[count-1] = 32'd1;
                            else if ($signed(t) < $signed(acc))
                                entries[count-1] = '1;
                            else
                                entries[count-1] = '0;
                        end
                    endcase
                end
            end
            s.acc = acc;
            s.top = (count > 0) ? entries[count-1] : '0;
            s.depth = DEPTH_W'(count);
            s.status = st;
            pending.push_back(s);
        endfunction

        function void report_field(string name, logic [DATA_W-1:0] e, logic [DATA_W-1:0] a);
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, e, a);
        endfunction

        function void compare_state(t_sam_state seen);
            t_sam_state want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got %h", $time, seen);
                return;
            end
            want = pending[0];
            pending.delete(0);
            if (seen.acc !== want.acc)
                report_field("accumulator", want.acc, seen.acc);
            if (seen.top !== want.top)
                report_field("top_value", want.top, seen.top);
            if (seen.depth !== want.depth)
                report_field("depth", DATA_W'(want.depth), DATA_W'(seen.depth));
            if (seen.status !== want.status)
                report_field("status", DATA_W'(want.status), DATA_W'(seen.status));
        endfunction
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic        [FUNC_W-1:0]    i_func;
    logic signed [DATA_W-1:0]    i_immediate;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic signed [DATA_W-1:0]    o_accumulator;
    logic signed [DATA_W-1:0]    o_top_value;
    logic        [DEPTH_W-1:0]   o_depth;
    logic        [STATUS_W-1:0]  o_status;

    stack_machine_tracker tracker;
    int unsigned          cycle_count = 0;
    int                   random_sent;
    bit                   no_gaps;

    stack_accumulator_machine #(
        .STACK_DEPTH (STACK_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_immediate   (i_immediate),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_accumulator (o_accumulator),
        .o_top_value   (o_top_value),
        .o_depth       (o_depth),
        .o_status      (o_status)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin : monitor
        t_sam_state seen;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                tracker.execute_instr(i_func, i_immediate);
            if (o_out_valid && !i_out_stall) begin
                seen.acc = o_accumulator;
                seen.top = o_top_value;
                seen.depth = o_depth;
                seen.status = o_status;
                tracker.compare_state(seen);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // output stall: quiet stretches, random chatter, and a few long holds
    initial begin : out_stall_gen
        int mode;
        int run;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            mode = $urandom_range(99);
            if (mode < 45) begin
                run = $urandom_range(40, 5);
                repeat (run) begin
                    @(negedge i_clk);
                    i_out_stall <= 1'b0;
                end
            end else if (mode < 88) begin
                run = $urandom_range(30, 5);
                repeat (run) begin
                    @(negedge i_clk);
                    i_out_stall <= ($urandom_range(99) < 30);
                end
            end else begin
                run = $urandom_range(40, 10);
                repeat (run) begin
                    @(negedge i_clk);
                    i_out_stall <= 1'b1;
                end
            end
        end
    end

    function automatic int next_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 8);
    endfunction

    function automatic logic [DATA_W-1:0] next_value();
        int r;
        r = $urandom_range(99);
        if (r < 15) begin
            case ($urandom_range(4))
                0: return VAL_MAX;
                1: return VAL_MIN;
                2: return '0;
                3: return '1;
                default: return 32'd1;
            endcase
        end else if (r < 35) begin
            return DATA_W'($signed($urandom_range(20)) - 10);
        end else if (r < 45) begin
            // same as accumulator so compare can hit equality
            return tracker.acc;
        end
        return $urandom();
    endfunction

    function automatic logic [FUNC_W-1:0] popping_op();
        case ($urandom_range(3))
            0: return FUNC_POP;
            1: return FUNC_ADD;
            2: return FUNC_SUB;
            default: return FUNC_CMP;
        endcase
    endfunction

    function automatic logic [FUNC_W-1:0] noop_op();
        case ($urandom_range(2))
            0: return FUNC_RSVD5;
            1: return FUNC_RSVD6;
            default: return FUNC_RSVD7;
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(logic [FUNC_W-1:0] op, logic [DATA_W-1:0] imm);
        int gap;
        gap = next_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= op;
        i_immediate <= imm;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        if (op <= FUNC_CMP)
            random_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        do
            @(negedge i_clk);
        while (tracker.pending.size() != 0);
    endtask

    task automatic run_directed();
        // every popping op on an empty stack underflows
        send_item(FUNC_POP, 32'h0);
        send_item(FUNC_ADD, '1);
        send_item(FUNC_SUB, 32'h0);
        send_item(FUNC_CMP, '1);
        send_item(FUNC_RSVD5, '1);
        send_item(FUNC_RSVD6, VAL_MIN);
        send_item(FUNC_RSVD7, VAL_MAX);
        // wrap in both directions
        send_item(FUNC_PUSH, VAL_MAX);
        send_item(FUNC_POP, 32'h0);
        send_item(FUNC_PUSH, 32'd1);
        send_item(FUNC_ADD, '1);
        send_item(FUNC_PUSH, 32'd1);
        send_item(FUNC_SUB, '1);
        // compare: equal, then greater after the accumulator drops to min
        send_item(FUNC_PUSH, VAL_MAX);
        send_item(FUNC_CMP, 32'h0);
        send_item(FUNC_PUSH, VAL_MIN);
        send_item(FUNC_POP, 32'h0);
        send_item(FUNC_CMP, 32'h0);
        send_item(FUNC_PUSH, 32'h5555_aaaa);
        send_item(FUNC_PUSH, '1);
        send_item(FUNC_CMP, 32'h0);
    endtask

    // fill to the top, overflow once, then compare on the full stack
    task automatic fill_stack();
        while (tracker.count < STACK_DEPTH)
            send_item(FUNC_PUSH, next_value());
        send_item(FUNC_PUSH, next_value());
        send_item(FUNC_CMP, $urandom());
    endtask

    task automatic drain_stack();
        while (tracker.count > 0)
            send_item(popping_op(), $urandom());
        send_item(popping_op(), $urandom());
    endtask

    task automatic wander(int n);
        int r;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 47)
                send_item(FUNC_PUSH, next_value());
            else if (r < 96)
                send_item(popping_op(), $urandom());
            else
                send_item(noop_op(), $urandom());
        end
    endtask

    task automatic run_random();
        int  kind;
        bit  paused;
        bit  first;
        paused = 1'b0;
        first = 1'b1;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            no_gaps = ($urandom_range(99) < 25);
            kind = first ? 0 : $urandom_range(99);
            first = 1'b0;
            if (kind < 15)
                fill_stack();
            else if (kind < 30)
                drain_stack();
            else if (kind < 92)
                wander($urandom_range(30, 10));
            else
                repeat ($urandom_range(4, 1)) send_item(noop_op(), $urandom());
            if (!paused && random_sent >= RANDOM_ITEMS / 2) begin
                paused = 1'b1;
                wait_results_drained();
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        tracker = new();
        no_gaps = 1'b0;
        random_sent = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_func = FUNC_PUSH;
        i_immediate = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        run_directed();
        run_random();
        i_in_valid <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (tracker.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/sam_pkg.sv
design/sam_ram.sv
design/sam_exec.sv
design/stack_accumulator_machine.sv
dv/stack_accumulator_machine_tb.sv
